FILE: hw/rtl/cpvl_pkg.sv
`default_nettype none

package cpvl_pkg;

   // Field and datapath widths.
   localparam int ANG_W      = 16;
   localparam int ERR_W      = 17;
   localparam int GAIN_W     = 16;
   localparam int RATE_W     = 10;
   localparam int TOL_W      = 15;
   localparam int INTEG_W    = 24;
   localparam int VERR_W     = 36;
   localparam int ACC_W      = 64;
   localparam int DRIVE_W    = 16;

   // Shared multiplier: signed A by signed B, wide operands split at SPLIT bits.
   localparam int MUL_A_W    = 25;
   localparam int MUL_B_W    = 17;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
   localparam int SPLIT      = 23;

   // Port widths.
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   // Saturation limits.
   localparam logic signed [ACC_W-1:0] INTEG_LIMIT = 64'sd5242880;
   localparam logic signed [ACC_W-1:0] SUM_LIMIT   = 64'sd70368744177664;
   localparam logic signed [ACC_W-1:0] DRIVE_LIMIT = 64'sd16384;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_KP,
      CSR_FEED_GAIN,
      CSR_TAU_R,
      CSR_LOOP_TIME,
      CSR_LOOP_RATE,
      CSR_MAX_TIMEOUT,
      CSR_TOLERANCE,
      CSR_ANGLE_OFFSET
   } csr_index_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_op_type;

   function automatic logic signed [ACC_W-1:0] clamp_acc(
      input logic signed [ACC_W-1:0] v,
      input logic signed [ACC_W-1:0] lim
   );
      logic signed [ACC_W-1:0] r;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/cpvl_mul.sv
`default_nettype none

// Registered signed multiplier, shared by every product of the loop.
module cpvl_mul import cpvl_pkg::*; (
   input  wire logic               clock,
   input  wire mul_op_type         op,
   output logic [MUL_P_W-1:0]      prod
);

   logic [MUL_P_W-1:0] prod_ff;
   logic [MUL_P_W-1:0] prod_in;

   assign prod_in = MUL_P_W'($signed(op.a) * $signed(op.b));

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/cascaded_position_velocity_loop.sv
`default_nettype none

// Channel  | Direction | Handshake            | Contents
// ---------+-----------+----------------------+---------------------------------------------
// req      | in        | req_tvalid/tready    | tuser: item kind; tdata: sample, target
// rsp      | out       | rsp_tvalid/tready    | tdata: drive, motion, at-target, pos. error
// csr      | in        | csr_we (no wait)     | register index and 16 bit write data
//
// A control tick that runs the loop walks the sequencer states in turn, from acceptance
// to the result and back to idle; no new item is taken until the block is idle again.
// The sequencer walks one shared 25x17 multiplier and one 64 bit adder
// through eight products and their sums. A set-target transaction, or a tick outside
// a motion, goes straight to the result state. Reset is synchronous and restores the register defaults
// and clears all loop state. A stalled result waits in the output register; the
// block accepts the next item meanwhile but holds its own result until that one leaves.

module cascaded_position_velocity_loop import cpvl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] angle_sample, [31:16] target_angle
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type (0 = control tick, 1 = set target)
   input  wire logic [0:0]            req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [15:0] motor_cmd, [16] in_motion, [17] at_target, [34:18] position_error,
   // [39:35] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KP,
      ST_RATE,
      ST_VERR,
      ST_LT_LO,
      ST_LT_HI,
      ST_LT_ADD,
      ST_INTEG,
      ST_TAU_HI,
      ST_TAU_ADD,
      ST_SUM,
      ST_FG_LO,
      ST_FG_HI,
      ST_FG_ADD,
      ST_DRIVE,
      ST_DONE
   } state_type;

   // Configuration registers.
   logic [GAIN_W-1:0]        kp_ff;
   logic [GAIN_W-1:0]        feed_gain_ff;
   logic [GAIN_W-1:0]        tau_r_ff;
   logic [GAIN_W-1:0]        loop_time_ff;
   logic [RATE_W-1:0]        loop_rate_ff;
   logic [GAIN_W-1:0]        max_timeout_ff;
   logic [TOL_W-1:0]         tolerance_ff;
   logic signed [ANG_W-1:0]  angle_offset_ff;

   // Loop state.
   state_type                state_ff;
   logic                     moving_ff;
   logic [GAIN_W-1:0]        tick_ff;
   logic signed [ANG_W-1:0]  cur_ff;
   logic signed [ANG_W-1:0]  target_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [DRIVE_W-1:0] drive_ff;

   // Working registers of one control tick.
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [ERR_W-1:0]  diff_ff;
   logic signed [VERR_W-1:0] verr_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Output register.
   logic                     rsp_tvalid_ff;
   logic [DRIVE_W-1:0]       rsp_motor_ff;
   logic                     rsp_motion_ff;
   logic                     rsp_at_ff;
   logic [ERR_W-1:0]         rsp_err_ff;

   // Combinational signals.
   logic signed [ANG_W-1:0]  req_sample;
   logic signed [ANG_W-1:0]  req_target;
   logic signed [ANG_W:0]    offs_diff;
   logic signed [ANG_W-1:0]  ang_in;
   logic signed [ERR_W-1:0]  err_in;
   logic signed [ERR_W-1:0]  diff_in;
   logic                     control;
   logic                     out_free;

   mul_op_type               mul_op;
   logic [MUL_P_W-1:0]       prod;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  integ_ext;
   logic signed [ACC_W-1:0]  verr_ext;
   logic [MUL_A_W-1:0]       acc_lo;
   logic [MUL_A_W-1:0]       acc_hi;
   logic [MUL_A_W-1:0]       verr_lo;
   logic [MUL_A_W-1:0]       verr_hi;

   logic signed [ACC_W-1:0]  add_a;
   logic signed [ACC_W-1:0]  add_b;
   logic                     add_sub;
   logic signed [ACC_W-1:0]  add_res;
   logic signed [ACC_W-1:0]  integ_sat;
   logic signed [ACC_W-1:0]  sum_sat;
   logic signed [ACC_W-1:0]  drive_wide;
   logic signed [ACC_W-1:0]  drive_sat;
   logic signed [DRIVE_W-1:0] drive_in;

   logic [ERR_W:0]           err_wide;
   logic [ERR_W:0]           err_mag;
   logic                     at_in;

   // ------------------------------------------------------------------
   // Configuration port. Writes land directly; there is no read-back.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff           <= 16'd256;
         feed_gain_ff    <= 16'd256;
         tau_r_ff        <= 16'd6554;
         loop_time_ff    <= 16'd1311;
         loop_rate_ff    <= 10'd50;
         max_timeout_ff  <= 16'd250;
         tolerance_ff    <= 15'd128;
         angle_offset_ff <= 16'sd0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_KP:           kp_ff           <= csr_wdata;
            CSR_FEED_GAIN:    feed_gain_ff    <= csr_wdata;
            CSR_TAU_R:        tau_r_ff        <= csr_wdata;
            CSR_LOOP_TIME:    loop_time_ff    <= csr_wdata;
            CSR_LOOP_RATE:    loop_rate_ff    <= csr_wdata[RATE_W-1:0];
            CSR_MAX_TIMEOUT:  max_timeout_ff  <= csr_wdata;
            CSR_TOLERANCE:    tolerance_ff    <= csr_wdata[TOL_W-1:0];
            CSR_ANGLE_OFFSET: angle_offset_ff <= $signed(csr_wdata);
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Front end: the sample less the calibration offset, saturated to the
   // 16 bit angle range, then the position error and the angle step.
   // ------------------------------------------------------------------
   assign req_sample = $signed(req_tdata[ANG_W-1:0]);
   assign req_target = $signed(req_tdata[2*ANG_W-1:ANG_W]);

   assign offs_diff = {req_sample[ANG_W-1], req_sample}
                    - {angle_offset_ff[ANG_W-1], angle_offset_ff};

   always_comb begin
      if (offs_diff > 17'sd32767) begin
         ang_in = 16'sh7FFF;
      end else if (offs_diff < -17'sd32768) begin
         ang_in = 16'sh8000;
      end else begin
         ang_in = offs_diff[ANG_W-1:0];
      end
   end

   // The angle step is taken against the angle held from the last tick.
   assign err_in  = {target_ff[ANG_W-1], target_ff} - {ang_in[ANG_W-1], ang_in};
   assign diff_in = {ang_in[ANG_W-1], ang_in} - {cur_ff[ANG_W-1], cur_ff};

   // The loop runs only inside a motion that has ticks left.
   assign control  = moving_ff && (tick_ff < max_timeout_ff);
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // ------------------------------------------------------------------
   // Shared multiplier. Wide operands (the velocity error and the clamped
   // sum) go through in two halves: the low SPLIT bits unsigned, the rest
   // signed, and the adder recombines them with a shift of SPLIT.
   // ------------------------------------------------------------------
   assign verr_ext = {{(ACC_W-VERR_W){verr_ff[VERR_W-1]}}, verr_ff};
   assign acc_lo   = {{(MUL_A_W-SPLIT){1'b0}}, acc_ff[SPLIT-1:0]};
   assign acc_hi   = acc_ff[SPLIT+MUL_A_W-1:SPLIT];
   assign verr_lo  = {{(MUL_A_W-SPLIT){1'b0}}, verr_ext[SPLIT-1:0]};
   assign verr_hi  = verr_ext[SPLIT+MUL_A_W-1:SPLIT];

   always_comb begin
      unique case (state_ff)
         ST_KP: begin
            mul_op.a = {{(MUL_A_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, kp_ff};
         end
         ST_RATE: begin
            mul_op.a = {{(MUL_A_W-ERR_W){diff_ff[ERR_W-1]}}, diff_ff};
            mul_op.b = {{(MUL_B_W-RATE_W){1'b0}}, loop_rate_ff};
         end
         ST_LT_LO: begin
            mul_op.a = acc_lo;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, loop_time_ff};
         end
         ST_LT_HI: begin
            mul_op.a = verr_hi;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, loop_time_ff};
         end
         ST_INTEG: begin
            mul_op.a = verr_lo;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, tau_r_ff};
         end
         ST_TAU_HI: begin
            mul_op.a = verr_hi;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, tau_r_ff};
         end
         ST_FG_LO: begin
            mul_op.a = acc_lo;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, feed_gain_ff};
         end
         ST_FG_HI: begin
            mul_op.a = acc_hi;
            mul_op.b = {{(MUL_B_W-GAIN_W){1'b0}}, feed_gain_ff};
         end
         default: begin
            mul_op.a = '0;
            mul_op.b = '0;
         end
      endcase
   end

   cpvl_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   // ------------------------------------------------------------------
   // Shared adder. Right shifts are arithmetic, which gives the floored
   // division the fixed-point scaling needs.
   // ------------------------------------------------------------------
   assign prod_ext  = {{(ACC_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};
   assign integ_ext = {{(ACC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};

   always_comb begin
      unique case (state_ff)
         ST_VERR: begin
            // kp * error less the measured velocity, both in Q.14 deg/s
            add_a   = acc_ff;
            add_b   = prod_ext <<< 8;
            add_sub = 1'b1;
         end
         ST_LT_ADD, ST_TAU_ADD, ST_FG_ADD: begin
            add_a   = acc_ff;
            add_b   = prod_ext <<< SPLIT;
            add_sub = 1'b0;
         end
         ST_INTEG: begin
            add_a   = integ_ext;
            add_b   = acc_ff >>> 11;
            add_sub = 1'b0;
         end
         ST_SUM: begin
            add_a   = acc_ff;
            add_b   = integ_ext <<< 11;
            add_sub = 1'b0;
         end
         default: begin
            add_a   = '0;
            add_b   = '0;
            add_sub = 1'b0;
         end
      endcase
   end

   assign add_res    = add_sub ? (add_a - add_b) : (add_a + add_b);
   assign integ_sat  = clamp_acc(add_res, INTEG_LIMIT);
   assign sum_sat    = clamp_acc(add_res, SUM_LIMIT);
   assign drive_wide = acc_ff >>> 24;
   assign drive_sat  = clamp_acc(drive_wide, DRIVE_LIMIT);
   assign drive_in   = drive_sat[DRIVE_W-1:0];

   // At-target compares the magnitude of the held error, which needs one
   // extra bit because the most negative error has no positive twin.
   assign err_wide = {last_err_ff[ERR_W-1], last_err_ff};
   assign err_mag  = err_wide[ERR_W] ? (~err_wide + (ERR_W+1)'(1)) : err_wide;
   assign at_in    = err_mag < {{(ERR_W+1-TOL_W){1'b0}}, tolerance_ff};

   // ------------------------------------------------------------------
   // Sequencer, loop state and output register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         moving_ff     <= 1'b0;
         tick_ff       <= '0;
         cur_ff        <= '0;
         target_ff     <= '0;
         integ_ff      <= '0;
         last_err_ff   <= '0;
         drive_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         // A new result is loaded as the waiting one leaves, or into an
         // empty output register.
         if ((state_ff == ST_DONE) && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  if (req_tuser[0]) begin
                     // Set target: start a fresh motion.
                     target_ff <= req_target;
                     moving_ff <= 1'b1;
                     tick_ff   <= '0;
                     state_ff  <= ST_DONE;
                  end else begin
                     cur_ff  <= ang_in;
                     err_ff  <= err_in;
                     diff_ff <= diff_in;
                     if (control) begin
                        last_err_ff <= err_in;
                        tick_ff     <= tick_ff + 16'd1;
                        state_ff    <= ST_KP;
                     end else begin
                        // Out of ticks or not moving: drive off, motion over.
                        drive_ff  <= '0;
                        moving_ff <= 1'b0;
                        tick_ff   <= '0;
                        state_ff  <= ST_DONE;
                     end
                  end
               end
            end
            ST_KP: begin
               state_ff <= ST_RATE;
            end
            ST_RATE: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_VERR;
            end
            ST_VERR: begin
               acc_ff   <= add_res;
               state_ff <= ST_LT_LO;
            end
            ST_LT_LO: begin
               verr_ff  <= acc_ff[VERR_W-1:0];
               state_ff <= ST_LT_HI;
            end
            ST_LT_HI: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_LT_ADD;
            end
            ST_LT_ADD: begin
               acc_ff   <= add_res;
               state_ff <= ST_INTEG;
            end
            ST_INTEG: begin
               integ_ff <= integ_sat[INTEG_W-1:0];
               state_ff <= ST_TAU_HI;
            end
            ST_TAU_HI: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_TAU_ADD;
            end
            ST_TAU_ADD: begin
               acc_ff   <= add_res;
               state_ff <= ST_SUM;
            end
            ST_SUM: begin
               acc_ff   <= sum_sat;
               state_ff <= ST_FG_LO;
            end
            ST_FG_LO: begin
               state_ff <= ST_FG_HI;
            end
            ST_FG_HI: begin
               acc_ff   <= prod_ext;
               state_ff <= ST_FG_ADD;
            end
            ST_FG_ADD: begin
               acc_ff   <= add_res;
               state_ff <= ST_DRIVE;
            end
            ST_DRIVE: begin
               drive_ff <= drive_in;
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_motor_ff  <= drive_ff;
                  rsp_motion_ff <= moving_ff;
                  rsp_at_ff     <= at_in;
                  rsp_err_ff    <= last_err_ff;
                  state_ff      <= ST_IDLE;
               end
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-DRIVE_W-2-ERR_W){1'b0}},
                        rsp_err_ff, rsp_at_ff, rsp_motion_ff, rsp_motor_ff};

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block took a second transaction straight after the first");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      (drive_ff >= -16'sd16384) && (drive_ff <= 16'sd16384))
      else $error("held drive outside the saturation range");

   a_integ_range: assert property (@(posedge clock) disable iff (reset)
      (integ_ff >= -24'sd5242880) && (integ_ff <= 24'sd5242880))
      else $error("velocity integral outside its clamp");

   a_tick_idle: assert property (@(posedge clock) disable iff (reset)
      !moving_ff |-> (tick_ff == '0))
      else $error("tick counter running outside a motion");
`endif

endmodule

`default_nettype wire
